/* rtl/hlcd_pkg.sv */
`default_nettype none

package hlcd_pkg;

  // default width of the received byte counter
  localparam int unsigned CountBitsDef = 32;

  // length of the header name that is searched for
  localparam int unsigned NameLen = 15;

  // magnitude cap of the parsed value, one above the largest positive value
  localparam logic [31:0] AccCap = 32'h8000_0000;
  localparam logic [31:0] PosMax = 32'h7FFF_FFFF;

  // character codes
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChHt    = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;

  // phase of the value parser
  typedef enum logic [2:0] {
    PH_NAME,
    PH_BLANK,
    PH_SIGN,
    PH_DIGIT,
    PH_END
  } phase_e;

  // lower-case header name "content-length:"
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h6C; // l
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      4'd14:   ch = 8'h3A; // :
      default: ch = 8'hFF; // unused index; only a byte of 8'hFF, which the letter fold leaves unchanged, would match it
    endcase
    return ch;
  endfunction

  // ascii letters to lower case, everything else unchanged
  function automatic logic [7:0] to_lower(input logic [7:0] ch);
    logic [7:0] res;
    res = ch;
    if (ch >= ChUpA && ch <= ChUpZ) begin
      res = ch + 8'd32;
    end
    return res;
  endfunction

  // whitespace as atoi skips it
  function automatic logic is_blank(input logic [7:0] ch);
    return (ch == ChSpace) || (ch >= ChHt && ch <= ChCr);
  endfunction

endpackage

`default_nettype wire

/* rtl/hlcd_if.sv */
`default_nettype none

// byte stream into the detector
interface hlcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink   (input valid, input data_byte, input first, output ready);
endinterface

// status stream out of the detector, one transfer per byte
interface hlcd_out_if;
  logic        valid;
  logic        ready;
  logic        complete;
  logic        length_found;
  logic        header_found;
  logic [31:0] header_length;

  modport source (output valid, output complete, output length_found,
                  output header_found, output header_length, input ready);
  modport sink   (input valid, input complete, input length_found,
                  input header_found, input header_length, output ready);
endinterface

`default_nettype wire

/* rtl/http_length_complete_detector.sv */
`default_nettype none
// each transferred byte's status is registered into the result register
// throughput: one byte per cycle unless the result stalls; the state update and completion
//   compare run in a single pass between the state registers and the result register
// reset: rst_ni clears all search state and empties the result register;
//   a byte flagged first clears the per-response state before it is taken

module http_length_complete_detector
  import hlcd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hlcd_in_if.sink   in_i,
  hlcd_out_if.source res_o
);

  // compare width covers the counter, a 32 bit header length and the sign
  localparam int unsigned CW = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 2;

  logic [COUNT_BITS-1:0] byte_count_q, byte_count_d;
  logic [3:0]            name_idx_q, name_idx_d;
  phase_e                phase_q, phase_d;
  logic                  neg_q, neg_d;
  logic [31:0]           accum_q, accum_d;
  logic                  cr_seen_q, cr_seen_d;
  logic                  len_valid_q, len_valid_d;
  logic [1:0]            blank_idx_q, blank_idx_d;
  logic                  hdr_done_q, hdr_done_d;
  logic [31:0]           hdr_bytes_q, hdr_bytes_d;
  logic                  zero_seen_q, zero_seen_d;

  logic                  res_valid_q;
  logic                  complete_q, complete_d;
  logic                  len_found_q;
  logic                  hdr_found_q;
  logic [31:0]           hdr_len_q;

  logic                  in_xfer;
  logic [7:0]            ch;

  // a byte is taken whenever the result register is free or being emptied
  assign in_i.ready = !res_valid_q || res_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign ch         = in_i.data_byte;

  // per-byte state update
  always_comb begin
    logic [COUNT_BITS-1:0] cnt_cur;
    logic [7:0]            low_ch;
    logic                  dig;
    logic                  take_digit;
    logic [35:0]           prod;
    logic [CW-1:0]         cnt_ext;

    // first byte of a response starts from the cleared state
    cnt_cur     = in_i.first ? '0 : byte_count_q;
    name_idx_d  = in_i.first ? 4'd0 : name_idx_q;
    phase_d     = in_i.first ? PH_NAME : phase_q;
    neg_d       = in_i.first ? 1'b0 : neg_q;
    accum_d     = in_i.first ? 32'd0 : accum_q;
    cr_seen_d   = in_i.first ? 1'b0 : cr_seen_q;
    len_valid_d = in_i.first ? 1'b0 : len_valid_q;
    blank_idx_d = in_i.first ? 2'd0 : blank_idx_q;
    hdr_done_d  = in_i.first ? 1'b0 : hdr_done_q;
    hdr_bytes_d = in_i.first ? 32'd0 : hdr_bytes_q;
    zero_seen_d = (in_i.first ? 1'b0 : zero_seen_q) || (ch == ChNul);

    low_ch     = to_lower(ch);
    dig        = (ch >= ChZero) && (ch <= ChNine);
    take_digit = 1'b0;
    prod       = (36'(accum_d) << 3) + (36'(accum_d) << 1) + 36'(ch - ChZero);

    // saturating byte counter
    byte_count_d = (cnt_cur == {COUNT_BITS{1'b1}}) ? cnt_cur : cnt_cur + 1'b1;
    cnt_ext      = CW'(byte_count_d);

    if (!zero_seen_d) begin
      // name search, then value parse up to crlf
      if (phase_d == PH_NAME) begin
        if (low_ch == name_char(name_idx_d)) begin
          if (name_idx_d == 4'(NameLen - 1)) begin
            name_idx_d = 4'd0;
            phase_d    = PH_BLANK;
          end else begin
            name_idx_d = name_idx_d + 4'd1;
          end
        end else begin
          name_idx_d = (low_ch == name_char(4'd0)) ? 4'd1 : 4'd0;
        end
      end else if (!len_valid_d) begin
        if (ch == ChLf && cr_seen_d) begin
          len_valid_d = 1'b1;
        end else begin
          cr_seen_d = (ch == ChCr);
          unique case (phase_d)
            PH_BLANK: begin
              if (is_blank(ch)) begin
                take_digit = 1'b0;
              end else if (ch == ChPlus || ch == ChMinus) begin
                neg_d   = (ch == ChMinus);
                phase_d = PH_SIGN;
              end else begin
                take_digit = 1'b1;
              end
            end
            PH_SIGN, PH_DIGIT: take_digit = 1'b1;
            default:           take_digit = 1'b0;
          endcase
          if (take_digit) begin
            if (dig) begin
              accum_d = (prod > 36'(AccCap)) ? AccCap : prod[31:0];
              phase_d = PH_DIGIT;
            end else begin
              phase_d = PH_END;
            end
          end
        end
      end

      // blank line search
      if (!hdr_done_d) begin
        unique case (blank_idx_d)
          2'd0: blank_idx_d = (ch == ChCr) ? 2'd1 : 2'd0;
          2'd1: blank_idx_d = (ch == ChLf) ? 2'd2 : (ch == ChCr) ? 2'd1 : 2'd0;
          2'd2: blank_idx_d = (ch == ChCr) ? 2'd3 : 2'd0;
          default: begin
            if (ch == ChLf) begin
              hdr_done_d  = 1'b1;
              blank_idx_d = 2'd0;
              hdr_bytes_d = (cnt_ext > CW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                           : cnt_ext[31:0];
            end else begin
              blank_idx_d = (ch == ChCr) ? 2'd1 : 2'd0;
            end
          end
        endcase
      end
    end
  end

  // completion compare; the value is frozen once the length line is valid,
  // so the stored value serves whenever the compare can pass
  always_comb begin
    logic [31:0]          mag;
    logic signed [CW-1:0] len;
    logic signed [CW-1:0] need;
    logic signed [CW-1:0] have;
    mag  = (accum_q > PosMax) ? PosMax : accum_q;
    len  = neg_q ? -$signed(CW'(accum_q)) : $signed(CW'(mag));
    need = $signed(CW'(hdr_bytes_d)) + len;
    have = $signed(CW'(byte_count_d));
    complete_d = len_valid_d && hdr_done_d && (have >= need);
  end

  // search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      name_idx_q   <= 4'd0;
      phase_q      <= PH_NAME;
      neg_q        <= 1'b0;
      accum_q      <= 32'd0;
      cr_seen_q    <= 1'b0;
      len_valid_q  <= 1'b0;
      blank_idx_q  <= 2'd0;
      hdr_done_q   <= 1'b0;
      hdr_bytes_q  <= 32'd0;
      zero_seen_q  <= 1'b0;
    end else if (in_xfer) begin
      byte_count_q <= byte_count_d;
      name_idx_q   <= name_idx_d;
      phase_q      <= phase_d;
      neg_q        <= neg_d;
      accum_q      <= accum_d;
      cr_seen_q    <= cr_seen_d;
      len_valid_q  <= len_valid_d;
      blank_idx_q  <= blank_idx_d;
      hdr_done_q   <= hdr_done_d;
      hdr_bytes_q  <= hdr_bytes_d;
      zero_seen_q  <= zero_seen_d;
    end
  end

  // result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_xfer) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      complete_q  <= complete_d;
      len_found_q <= len_valid_d;
      hdr_found_q <= hdr_done_d;
      hdr_len_q   <= hdr_bytes_d;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.complete      = complete_q;
  assign res_o.length_found  = len_found_q;
  assign res_o.header_found  = hdr_found_q;
  assign res_o.header_length = hdr_len_q;

`ifndef SYNTHESIS
  // completion needs both the length line and the blank line
  a_complete_needs_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && complete_q |-> len_found_q && hdr_found_q)
    else $error("complete without length and header");

  // header length is zero exactly while the header is still open
  a_hdr_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (hdr_found_q == (hdr_len_q != 32'd0)))
    else $error("header length disagrees with header found");

  // a stalled result is never overwritten by a new byte
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_o.ready |-> !in_xfer)
    else $error("byte taken while result stalled");

  // once found within a response, the header stays found
  a_hdr_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && hdr_done_q && !in_i.first |-> hdr_done_d)
    else $error("header found flag dropped");
`endif

endmodule

`default_nettype wire
